// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wga_pkg.sv =====
`timescale 1ns / 1ps

package wga_pkg;

    // Number of features supported by the storage.
    localparam int DIM = 16;
    localparam int IDX_W = $clog2(DIM);

    // Field widths fixed by the item format.
    localparam int VAL_W = 16;
    localparam int ACC_W = 64;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] FEAT_RESET = 5'd16;

    // Accumulator memory layout: packed Gram triangle, target correlation,
    // feature sums, then the three scalar totals.
    localparam int GRAM_DEPTH = DIM * (DIM + 1) / 2;
    localparam int TC_BASE = GRAM_DEPTH;
    localparam int FS_BASE = GRAM_DEPTH + DIM;
    localparam int SC_BASE = GRAM_DEPTH + 2 * DIM;
    localparam int STORE_DEPTH = SC_BASE + 3;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int TRI_W = 2 * IDX_W + 2;

    // Command queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Operation codes.
    localparam logic [1:0] OP_FEATURE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Read regions.
    localparam logic [1:0] REGION_GRAM = 2'd0;
    localparam logic [1:0] REGION_TCORR = 2'd1;
    localparam logic [1:0] REGION_FSUM = 2'd2;
    localparam logic [1:0] REGION_SCALAR = 2'd3;

    // Scalar selects within the scalar region.
    localparam logic [3:0] SEL_WEIGHT = 4'd0;
    localparam logic [3:0] SEL_TSUM = 4'd1;
    localparam logic [3:0] SEL_TSQUARE = 4'd2;

    typedef enum logic [1:0] {
        K_ELEM,
        K_READ,
        K_CLEAR
    } t_kind;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_kind                    kind;
        logic                     first;
        logic [IDX_W-1:0]         idx;
        logic [ADDR_W-1:0]        base;
        logic signed [VAL_W-1:0]  x;
        logic signed [VAL_W-1:0]  y;
        logic signed [VAL_W-1:0]  w;
        logic [ADDR_W-1:0]        rd_addr;
        logic                     rd_zero;
    } t_cmd;

    // Start of row v in the packed lower triangle: v*(v+1)/2.
    function automatic logic [ADDR_W-1:0] tri_base(input logic [IDX_W-1:0] v);
        logic [TRI_W-1:0] p;
        p = TRI_W'(v) * (TRI_W'(v) + TRI_W'(1));
        return ADDR_W'(p >> 1);
    endfunction

endpackage

// ===== hdl/wga_ifs.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface wga_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       operation;
    logic signed [wga_pkg::VAL_W-1:0] feature_value;
    logic signed [wga_pkg::VAL_W-1:0] target_value;
    logic signed [wga_pkg::VAL_W-1:0] sample_weight;
    logic [1:0]                       read_region;
    logic [3:0]                       read_row;
    logic [3:0]                       read_col;

    modport source (
        output valid, operation, feature_value, target_value, sample_weight,
        output read_region, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, operation, feature_value, target_value, sample_weight,
        input  read_region, read_row, read_col,
        output ready
    );
endinterface

// Result item channel.
interface wga_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [wga_pkg::ACC_W-1:0] read_value;
    logic                             saturated;

    modport source (output valid, read_value, saturated, input ready);
    modport sink (input valid, read_value, saturated, output ready);
endinterface

// Configuration write channel for the feature count register.
interface wga_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wga_pkg::CFG_W-1:0]  features_in_use;

    modport source (output valid, features_in_use, input ready);
    modport sink (input valid, features_in_use, output ready);
endinterface

// ===== hdl/wga_front.sv =====
`timescale 1ns / 1ps

module wga_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wga_in_if.sink        i_in,
    wga_cfg_if.sink       i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output wga_pkg::t_cmd o_cmd
);
    import wga_pkg::*;

    logic [CFG_W-1:0] r_feat_cnt;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] n_pos;
    logic [7:0]       cnt8;
    logic [7:0]       cfg8;
    logic [7:0]       pos8;
    logic [7:0]       idx8;
    logic [7:0]       nxt8;
    logic [7:0]       row8;
    logic [7:0]       col8;
    logic [7:0]       rr8;
    logic [7:0]       cc8;
    logic             accept;

    // The configuration register is always ready.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready = !i_full;
    assign accept = i_in.valid && !i_full;

    // Classify the item and work out its element index or read address.
    always_comb begin
        cfg8 = 8'(r_feat_cnt);
        if (cfg8 == 8'd0) begin
            cnt8 = 8'd1;
        end else if (cfg8 > 8'(DIM)) begin
            cnt8 = 8'(DIM);
        end else begin
            cnt8 = cfg8;
        end

        // A position at or past the count in use starts a new sample.
        pos8 = 8'(r_pos);
        idx8 = (pos8 >= cnt8) ? 8'd0 : pos8;
        nxt8 = idx8 + 8'd1;
        if (nxt8 >= cnt8) begin
            nxt8 = 8'd0;
        end

        // Gram reads above the diagonal are mirrored.
        row8 = 8'(i_in.read_row);
        col8 = 8'(i_in.read_col);
        if (col8 > row8) begin
            rr8 = col8;
            cc8 = row8;
        end else begin
            rr8 = row8;
            cc8 = col8;
        end

        o_cmd.first = (idx8 == 8'd0);
        o_cmd.idx = IDX_W'(idx8);
        o_cmd.base = tri_base(IDX_W'(idx8));
        o_cmd.x = i_in.feature_value;
        o_cmd.y = i_in.target_value;
        o_cmd.w = i_in.sample_weight;
        o_cmd.rd_addr = '0;
        o_cmd.rd_zero = 1'b0;

        case (i_in.read_region)
            REGION_GRAM: begin
                o_cmd.rd_addr = tri_base(IDX_W'(rr8)) + ADDR_W'(cc8);
                o_cmd.rd_zero = (rr8 >= 8'(DIM));
            end
            REGION_TCORR: begin
                o_cmd.rd_addr = ADDR_W'(TC_BASE) + ADDR_W'(row8);
                o_cmd.rd_zero = (row8 >= 8'(DIM));
            end
            REGION_FSUM: begin
                o_cmd.rd_addr = ADDR_W'(FS_BASE) + ADDR_W'(row8);
                o_cmd.rd_zero = (row8 >= 8'(DIM));
            end
            default: begin
                o_cmd.rd_addr = ADDR_W'(SC_BASE) + ADDR_W'(row8);
                o_cmd.rd_zero = (i_in.read_row > SEL_TSQUARE);
            end
        endcase

        case (i_in.operation)
            OP_FEATURE: begin
                o_cmd.kind = K_ELEM;
                o_push = accept;
                n_pos = IDX_W'(nxt8);
            end
            OP_READ: begin
                o_cmd.kind = K_READ;
                o_push = accept;
                n_pos = r_pos;
            end
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
                o_push = accept;
                n_pos = '0;
            end
            default: begin
                // Unused operation code: accepted and dropped.
                o_cmd.kind = K_CLEAR;
                o_push = 1'b0;
                n_pos = r_pos;
            end
        endcase
    end

    // Feature count register and position within the current sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat_cnt <= FEAT_RESET;
            r_pos <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_feat_cnt <= i_cfg.features_in_use;
            end
            if (accept) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

// ===== hdl/wga_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wga_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wga_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output wga_pkg::t_cmd o_cmd
);
    import wga_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd = r_slot[r_rp];

    // Command storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, r_count < QCNT_W'(QUEUE_DEPTH), "push into a full command queue")
    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty command queue")

endmodule

// ===== hdl/wga_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wga_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wga_pkg::t_cmd i_cmd,
    output logic          o_pop,
    wga_out_if.source     o_out
);
    import wga_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP_RD,
        S_STEP_WR,
        S_RESP
    } t_state;

    // Update steps of one element; the scalar steps run on a sample's first element.
    typedef enum logic [2:0] {
        ST_WT,
        ST_TS,
        ST_TQ,
        ST_FS,
        ST_TC,
        ST_GR
    } t_step;

    t_state                  r_state;
    t_step                   r_step;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_j;
    logic [ADDR_W-1:0]       r_base;
    logic signed [VAL_W-1:0] r_x;
    logic signed [VAL_W-1:0] r_hy;
    logic signed [VAL_W-1:0] r_hw;
    logic signed [31:0]      r_xw;
    logic signed [47:0]      r_prod;
    logic signed [VAL_W-1:0] r_feat [DIM];
    logic [STORE_DEPTH-1:0]  r_valid;
    logic                    r_flag;
    logic                    r_zero;
    logic                    r_rvalid;
    logic [ACC_W-1:0]        r_rdata;
    logic [ACC_W-1:0]        r_mem [STORE_DEPTH];
    logic                    r_ovalid;
    logic [ACC_W-1:0]        r_ovalue;
    logic                    r_osat;

    logic signed [31:0]      mul_a;
    logic signed [VAL_W-1:0] mul_b;
    logic signed [47:0]      prod;
    logic [ADDR_W-1:0]       step_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ACC_W-1:0]        old_val;
    logic [ACC_W-1:0]        add_val;
    logic [ACC_W:0]          sum_ext;
    logic                    ovf;
    logic [ACC_W-1:0]        wr_data;
    logic                    mem_we;

    assign o_out.valid = r_ovalid;
    assign o_out.read_value = r_ovalue;
    assign o_out.saturated = r_osat;

    // A read waits at the head of the queue until the output register is free.
    assign o_pop = (r_state == S_IDLE) && i_valid &&
                   ((i_cmd.kind != K_READ) || !r_ovalid || o_out.ready);

    // Multiplier operands and accumulator address for each update step.
    always_comb begin
        case (r_step)
            ST_WT: begin
                mul_a = 32'(r_hw);
                mul_b = 16'sd1;
                step_addr = ADDR_W'(SC_BASE) + ADDR_W'(SEL_WEIGHT);
            end
            ST_TS: begin
                mul_a = 32'(r_hy);
                mul_b = r_hw;
                step_addr = ADDR_W'(SC_BASE) + ADDR_W'(SEL_TSUM);
            end
            ST_TQ: begin
                // The product register still holds y*w from the previous step.
                mul_a = r_prod[31:0];
                mul_b = r_hy;
                step_addr = ADDR_W'(SC_BASE) + ADDR_W'(SEL_TSQUARE);
            end
            ST_FS: begin
                mul_a = 32'(r_x);
                mul_b = r_hw;
                step_addr = ADDR_W'(FS_BASE) + ADDR_W'(r_idx);
            end
            ST_TC: begin
                mul_a = r_xw;
                mul_b = r_hy;
                step_addr = ADDR_W'(TC_BASE) + ADDR_W'(r_idx);
            end
            default: begin
                mul_a = r_xw;
                mul_b = r_feat[r_j];
                step_addr = r_base + ADDR_W'(r_j);
            end
        endcase
        prod = $signed({{16{mul_a[31]}}, mul_a}) * $signed({{32{mul_b[15]}}, mul_b});
        rd_addr = (r_state == S_IDLE) ? i_cmd.rd_addr : step_addr;
    end

    // Saturating accumulate; an entry never written since clear reads as zero.
    always_comb begin
        old_val = r_rvalid ? r_rdata : '0;
        add_val = {{(ACC_W - 48){r_prod[47]}}, r_prod};
        sum_ext = {old_val[ACC_W-1], old_val} + {add_val[ACC_W-1], add_val};
        ovf = sum_ext[ACC_W] ^ sum_ext[ACC_W-1];
        if (!ovf) begin
            wr_data = sum_ext[ACC_W-1:0];
        end else if (sum_ext[ACC_W]) begin
            wr_data = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            wr_data = {1'b0, {(ACC_W - 1){1'b1}}};
        end
        mem_we = (r_state == S_STEP_WR);
    end

    // Accumulator memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[step_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Sequencer, valid bits, sticky flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= ST_FS;
            r_j <= '0;
            r_valid <= '0;
            r_flag <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[rd_addr];
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            K_ELEM: begin
                                r_idx <= i_cmd.idx;
                                r_base <= i_cmd.base;
                                r_x <= i_cmd.x;
                                r_feat[i_cmd.idx] <= i_cmd.x;
                                r_j <= '0;
                                if (i_cmd.first) begin
                                    r_hy <= i_cmd.y;
                                    r_hw <= i_cmd.w;
                                    r_step <= ST_WT;
                                end else begin
                                    r_step <= ST_FS;
                                end
                                r_state <= S_STEP_RD;
                            end
                            K_READ: begin
                                r_zero <= i_cmd.rd_zero;
                                r_state <= S_RESP;
                            end
                            default: begin
                                r_valid <= '0;
                                r_flag <= 1'b0;
                            end
                        endcase
                    end
                end
                S_STEP_RD: begin
                    r_prod <= prod;
                    r_state <= S_STEP_WR;
                end
                S_STEP_WR: begin
                    r_valid[step_addr] <= 1'b1;
                    if (ovf) begin
                        r_flag <= 1'b1;
                    end
                    // The last Gram column ends the element.
                    r_state <= (r_step == ST_GR && r_j == r_idx) ? S_IDLE : S_STEP_RD;
                    case (r_step)
                        ST_WT: r_step <= ST_TS;
                        ST_TS: r_step <= ST_TQ;
                        ST_TQ: r_step <= ST_FS;
                        ST_FS: begin
                            r_xw <= r_prod[31:0];
                            r_step <= ST_TC;
                        end
                        ST_TC: r_step <= ST_GR;
                        default: begin
                            if (r_j != r_idx) begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    endcase
                end
                default: begin
                    r_ovalid <= 1'b1;
                    r_ovalue <= (r_zero || !r_rvalid) ? '0 : r_rdata;
                    r_osat <= r_flag;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_resp_slot_free, i_clk, i_rst_n, r_state == S_RESP, !r_ovalid, "read result would overwrite a pending result")
    `ASSERT_IMPLIES(a_gram_col_bound, i_clk, i_rst_n, r_state != S_IDLE && r_step == ST_GR, r_j <= r_idx, "Gram column ran past the element index")
    `ASSERT_NEXT(a_clear_takes, i_clk, i_rst_n, o_pop && i_cmd.kind == K_CLEAR, !r_flag && r_valid == '0, "clear left state behind")

endmodule

// ===== hdl/weighted_gram_accumulator.sv =====
`timescale 1ns / 1ps

// Weighted Gram accumulator: takes one feature element per item and keeps the
// weighted Gram triangle, target correlations, feature sums and scalar totals
// as saturating 64-bit accumulators in a single memory with one read-modify-write
// port; each update has a read state and a write state. An element with index i
// updates its feature sum, target correlation and Gram columns 0 to i, after the
// three scalar totals on a sample's first element. Per-entry valid bits zero the
// stores at once on a clear; no clearing pass follows reset. A two-entry command
// queue keeps taking items while updates run, until it fills, and a result
// register holds a read result until it is taken. The user must write the feature
// count register only while the block is idle; the block does not enforce this.
module weighted_gram_accumulator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wga_in_if.sink    i_in,
    wga_cfg_if.sink   i_cfg,
    wga_out_if.source o_out
);
    import wga_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Accepts and classifies items.
    wga_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    // Decouples classification from the update engine.
    wga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Carries out updates, reads and clears.
    wga_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
